// ----- sv/icf_pkg.sv -----
// Shared types, constants and helpers for the integer display formatter.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps
`default_nettype none

package icf_pkg;

    // Longest character run: binary mode on a full word
    localparam int MAX_RUN   = 21;
    localparam int RUN_CNT_W = 5;

    // Display modes
    localparam logic [1:0] MODE_HEX = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_BIN = 2'd2;
    localparam logic [1:0] MODE_RAW = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_WIDE     = 2'd1;
    localparam logic [1:0] REG_BITS     = 2'd2;
    localparam logic [1:0] REG_SUPPRESS = 2'd3;

    localparam logic [4:0] VALUE_BITS_RST = 5'd8;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HEX_A = 8'h37;  // 'A' - 10

    typedef logic [7:0] char_t;
    typedef char_t [MAX_RUN-1:0] run_buf_t;  // element 0 goes out first

    typedef struct packed {
        logic [1:0] mode;
        logic       wide;
        logic [4:0] value_bits;
        logic       quiet;
    } reg_file_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       wide;
        logic       quiet;
    } fmt_cfg_t;

    typedef struct packed {
        fmt_cfg_t    cfg;
        logic [15:0] word;
        logic [3:0]  d4;
        logic [3:0]  d3;
        logic [3:0]  d2;
        logic [3:0]  d1;
        logic [3:0]  d0;
    } digit_item_t;

    typedef struct packed {
        run_buf_t             chars;
        logic [RUN_CNT_W-1:0] len;
    } run_item_t;

    function automatic char_t hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return CH_ZERO + {4'b0000, n};
        end
        return CH_HEX_A + {4'b0000, n};
    endfunction

    // Leading decimal digit of x for a constant place value (x < 10 * unit)
    function automatic logic [3:0] dec_digit(input logic [15:0] x, input logic [15:0] unit);
        logic [3:0]  d;
        logic [19:0] thr;
        d   = '0;
        thr = '0;
        for (int k = 1; k <= 9; k++)
        begin
            thr = 20'(k) * {4'b0000, unit};
            if ({4'b0000, x} >= thr)
            begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- sv/icf_apb_regs.sv -----
// Configuration register file behind an APB-style port.
// Depends on icf_pkg for register indexes and the register struct.
`timescale 1ns / 1ps
`default_nettype none

module icf_apb_regs import icf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output reg_file_t        regs
);

    reg_file_t  regs_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign regs   = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.mode       <= MODE_HEX;
            regs_reg.wide       <= 1'b0;
            regs_reg.value_bits <= VALUE_BITS_RST;
            regs_reg.quiet      <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MODE:     regs_reg.mode       <= pwdata[1:0];
                REG_WIDE:     regs_reg.wide       <= pwdata[0];
                REG_BITS:     regs_reg.value_bits <= pwdata[4:0];
                REG_SUPPRESS: regs_reg.quiet      <= pwdata[0];
                default:      regs_reg            <= regs_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:     prdata = {30'd0, regs_reg.mode};
            REG_WIDE:     prdata = {31'd0, regs_reg.wide};
            REG_BITS:     prdata = {27'd0, regs_reg.value_bits};
            REG_SUPPRESS: prdata = {31'd0, regs_reg.quiet};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/icf_digit_pipe.sv -----
// Mask stage plus four decimal digit stages, one place value per stage and tens and units in the last.
// Depends on icf_pkg for the item structs and the digit helper.
`timescale 1ns / 1ps
`default_nettype none

module icf_digit_pipe import icf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [15:0] in_value,
    input  reg_file_t        in_regs,
    output logic             in_ready,
    output logic             out_valid,
    output digit_item_t      out_item,
    input  wire logic        out_ready
);

    // Stage 1: masked word and the value to convert
    logic        s1_valid_reg;
    fmt_cfg_t    s1_cfg_reg;
    logic [15:0] s1_word_reg;
    logic [15:0] s1_rem_reg;
    // Stage 2: ten-thousands
    logic        s2_valid_reg;
    fmt_cfg_t    s2_cfg_reg;
    logic [15:0] s2_word_reg;
    logic [3:0]  s2_d4_reg;
    logic [13:0] s2_rem_reg;
    // Stage 3: thousands
    logic        s3_valid_reg;
    fmt_cfg_t    s3_cfg_reg;
    logic [15:0] s3_word_reg;
    logic [3:0]  s3_d4_reg;
    logic [3:0]  s3_d3_reg;
    logic [9:0]  s3_rem_reg;
    // Stage 4: hundreds
    logic        s4_valid_reg;
    fmt_cfg_t    s4_cfg_reg;
    logic [15:0] s4_word_reg;
    logic [3:0]  s4_d4_reg;
    logic [3:0]  s4_d3_reg;
    logic [3:0]  s4_d2_reg;
    logic [6:0]  s4_rem_reg;
    // Stage 5: tens and units
    logic        s5_valid_reg;
    digit_item_t s5_item_reg;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic [15:0] mask;
    logic [15:0] masked;
    logic [3:0]  d4, d3, d2, d1;

    assign rdy5     = !s5_valid_reg || out_ready;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    assign out_valid = s5_valid_reg;
    assign out_item  = s5_item_reg;

    // Sixteen or more bits keep the whole word
    assign mask   = in_regs.value_bits[4] ? 16'hFFFF : ~(16'hFFFF << in_regs.value_bits[3:0]);
    assign masked = in_value & mask;

    assign d4 = dec_digit(s1_rem_reg, 16'd10000);
    assign d3 = dec_digit({2'b00, s2_rem_reg}, 16'd1000);
    assign d2 = dec_digit({6'd0, s3_rem_reg}, 16'd100);
    assign d1 = dec_digit({9'd0, s4_rem_reg}, 16'd10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_valid_reg <= in_valid;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
            if (rdy3) s3_valid_reg <= s2_valid_reg;
            if (rdy4) s4_valid_reg <= s3_valid_reg;
            if (rdy5) s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_cfg_reg.mode  <= in_regs.mode;
            s1_cfg_reg.wide  <= in_regs.wide;
            s1_cfg_reg.quiet <= in_regs.quiet;
            s1_word_reg      <= masked;
            s1_rem_reg       <= in_regs.wide ? masked : {8'h00, masked[7:0]};
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_cfg_reg  <= s1_cfg_reg;
            s2_word_reg <= s1_word_reg;
            s2_d4_reg   <= d4;
            s2_rem_reg  <= 14'(s1_rem_reg - 16'(d4) * 16'd10000);
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_cfg_reg  <= s2_cfg_reg;
            s3_word_reg <= s2_word_reg;
            s3_d4_reg   <= s2_d4_reg;
            s3_d3_reg   <= d3;
            s3_rem_reg  <= 10'(s2_rem_reg - 14'(d3) * 14'd1000);
        end
        if (rdy4 && s3_valid_reg)
        begin
            s4_cfg_reg  <= s3_cfg_reg;
            s4_word_reg <= s3_word_reg;
            s4_d4_reg   <= s3_d4_reg;
            s4_d3_reg   <= s3_d3_reg;
            s4_d2_reg   <= d2;
            s4_rem_reg  <= 7'(s3_rem_reg - 10'(d2) * 10'd100);
        end
        if (rdy5 && s4_valid_reg)
        begin
            s5_item_reg.cfg  <= s4_cfg_reg;
            s5_item_reg.word <= s4_word_reg;
            s5_item_reg.d4   <= s4_d4_reg;
            s5_item_reg.d3   <= s4_d3_reg;
            s5_item_reg.d2   <= s4_d2_reg;
            s5_item_reg.d1   <= d1;
            s5_item_reg.d0   <= 4'(s4_rem_reg - 7'(d1) * 7'd10);
        end
    end

endmodule

`default_nettype wire

// ----- sv/icf_char_builder.sv -----
// Builds the full character run of one value into a registered buffer.
// Depends on icf_pkg for the item structs, ASCII codes and mode codes.
`timescale 1ns / 1ps
`default_nettype none

module icf_char_builder import icf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  digit_item_t in_item,
    output logic        in_ready,
    output logic        out_valid,
    output run_item_t   out_run,
    input  wire logic   out_ready
);

    logic      valid_reg;
    run_item_t run_reg;
    run_item_t run_next;

    logic [7:0]  hi, lo;
    logic [19:0] dec_vec;
    logic [19:0] dec_shift;
    logic [2:0]  lz;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_run   = run_reg;

    assign hi      = in_item.word[15:8];
    assign lo      = in_item.word[7:0];
    assign dec_vec = {in_item.d4, in_item.d3, in_item.d2, in_item.d1, in_item.d0};

    // Leading zeros to drop; the units digit always stays
    always_comb
    begin
        if (in_item.d4 != 4'd0)      lz = 3'd0;
        else if (in_item.d3 != 4'd0) lz = 3'd1;
        else if (in_item.d2 != 4'd0) lz = 3'd2;
        else if (in_item.d1 != 4'd0) lz = 3'd3;
        else                         lz = 3'd4;
    end

    assign dec_shift = dec_vec << {lz, 2'b00};

    always_comb
    begin
        run_next.chars = '0;
        run_next.len   = '0;
        case (in_item.cfg.mode)
            MODE_HEX:
            begin
                run_next.chars[0] = CH_ZERO;
                run_next.chars[1] = CH_X;
                if (in_item.cfg.wide)
                begin
                    run_next.chars[2] = hex_char(hi[7:4]);
                    run_next.chars[3] = hex_char(hi[3:0]);
                    run_next.chars[4] = hex_char(lo[7:4]);
                    run_next.chars[5] = hex_char(lo[3:0]);
                    run_next.len      = RUN_CNT_W'(6);
                end
                else
                begin
                    run_next.chars[2] = hex_char(lo[7:4]);
                    run_next.chars[3] = hex_char(lo[3:0]);
                    run_next.len      = RUN_CNT_W'(4);
                end
            end
            MODE_DEC:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    run_next.chars[i] = CH_ZERO + {4'b0000, dec_shift[19-4*i -: 4]};
                end
                run_next.len = RUN_CNT_W'(3'd5 - lz);
            end
            MODE_BIN:
            begin
                if (in_item.cfg.wide)
                begin
                    run_next.chars[0]  = CH_ZERO;
                    run_next.chars[1]  = CH_B;
                    for (int i = 0; i < 8; i++)
                    begin
                        run_next.chars[2+i]  = hi[7-i] ? CH_ONE : CH_ZERO;
                        run_next.chars[13+i] = lo[7-i] ? CH_ONE : CH_ZERO;
                    end
                    run_next.chars[10] = CH_SPACE;
                    run_next.chars[11] = CH_ZERO;
                    run_next.chars[12] = CH_B;
                    run_next.len       = RUN_CNT_W'(MAX_RUN);
                end
                else
                begin
                    run_next.chars[0] = CH_ZERO;
                    run_next.chars[1] = CH_B;
                    for (int i = 0; i < 8; i++)
                    begin
                        run_next.chars[2+i] = lo[7-i] ? CH_ONE : CH_ZERO;
                    end
                    run_next.len = RUN_CNT_W'(10);
                end
            end
            MODE_RAW:
            begin
                if (in_item.cfg.wide)
                begin
                    run_next.chars[0] = hi;
                    run_next.chars[1] = lo;
                    run_next.len      = RUN_CNT_W'(2);
                end
                else
                begin
                    run_next.chars[0] = lo;
                    run_next.len      = RUN_CNT_W'(1);
                end
            end
            default:
            begin
                run_next.len = '0;
            end
        endcase
        // Quiet values travel on as empty runs
        if (in_item.cfg.quiet)
        begin
            run_next.len = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/icf_serializer.sv -----
// Shifts one character run out, one character per cycle.
// Depends on icf_pkg for the run buffer type and its length.
`timescale 1ns / 1ps
`default_nettype none

module icf_serializer import icf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  run_item_t  in_run,
    output logic       in_ready,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic       last_char
);

    logic [RUN_CNT_W-1:0] cnt_reg;
    logic [RUN_CNT_W-1:0] cnt_next;
    run_buf_t             chars_reg;
    run_buf_t             chars_next;

    // Take the next run while the last character of this one goes out
    assign in_ready   = (cnt_reg[RUN_CNT_W-1:1] == '0);
    assign char_valid = (cnt_reg != '0);
    assign last_char  = (cnt_reg == RUN_CNT_W'(1));
    assign out_char   = chars_reg[0];

    always_comb
    begin
        cnt_next   = cnt_reg;
        chars_next = chars_reg;
        if (cnt_reg != '0)
        begin
            cnt_next   = cnt_reg - RUN_CNT_W'(1);
            chars_next = {8'h00, chars_reg[MAX_RUN-1:1]};
        end
        if (in_ready && in_valid && (in_run.len != '0))
        begin
            cnt_next   = in_run.len;
            chars_next = in_run.chars;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

endmodule

`default_nettype wire

// ----- sv/integer_display_formatter_core.sv -----
// Top level of the integer display formatter: config port, digit pipeline,
// character builder and output serializer. Depends on icf_pkg and all icf_* modules.
`timescale 1ns / 1ps
`default_nettype none

// A value is taken at a rising edge with start high and busy low. It is masked
// to its low value_bits bits and printed as a run of characters on out_char,
// one per cycle while char_valid is high, with last_char on the final one.
// The receiver cannot stall: each character is shown for exactly one cycle.
// Runs of one value are emitted without gaps, and back-to-back values follow
// each other with no idle cycle in between. The first character of a value
// passes the mask stage, four decimal digit stages, the character builder and
// the serializer before it is on out_char. The sustained rate is set by the
// serializer, which emits one character per cycle; a value has 1 to 21
// characters (21 for binary on a full word). A value in quiet mode produces
// no characters. Up to six values queue up in the pipeline ahead of the
// serializer; busy rises when it is full. Configuration registers are written
// through the APB-style port: 0 output format, 1 wide_values, 2 value_bits,
// 3 suppress_output, at byte addresses 0, 4, 8 and 12. The user must write
// them only while no transaction is in flight; the block itself does not
// enforce this.
module integer_display_formatter_core import icf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // value input
    input  wire logic        start,
    input  wire logic [15:0] value,
    output logic             busy,
    // character output
    output logic             char_valid,
    output logic [7:0]       out_char,
    output logic             last_char,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    reg_file_t   regs;
    logic        pipe_in_ready;
    logic        dig_valid;
    digit_item_t dig_item;
    logic        dig_ready;
    logic        run_valid;
    run_item_t   run_item;
    logic        run_ready;

    // Hold off new values only when every stage ahead of the serializer is full
    assign busy = !pipe_in_ready;

    icf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs)
    );

    // Mask, then split into decimal digits one place per stage, tens and units together in the last
    icf_digit_pipe u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_value  (value),
        .in_regs   (regs),
        .in_ready  (pipe_in_ready),
        .out_valid (dig_valid),
        .out_item  (dig_item),
        .out_ready (dig_ready)
    );

    // Assemble the whole run for the selected format
    icf_char_builder u_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dig_valid),
        .in_item   (dig_item),
        .in_ready  (dig_ready),
        .out_valid (run_valid),
        .out_run   (run_item),
        .out_ready (run_ready)
    );

    // Drain the run one character per cycle
    icf_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (run_valid),
        .in_run     (run_item),
        .in_ready   (run_ready),
        .char_valid (char_valid),
        .out_char   (out_char),
        .last_char  (last_char)
    );

`ifndef SYNTHESIS
    // The final-character mark only comes with a character
    assert property (@(posedge clk) disable iff (!rst_n) last_char |-> char_valid)
        else $error("last_char without char_valid");

    // A run continues without gaps until its final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !last_char) |=> char_valid)
        else $error("gap inside a character run");

    // The pipeline can only back up while the serializer is mid-run
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (char_valid && !last_char))
        else $error("busy while the serializer can take a run");
`endif

endmodule

`default_nettype wire
